// ===== rtl/deadline_release_scheduler_unit_macros.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef DEADLINE_RELEASE_SCHEDULER_UNIT_MACROS_SVH
`define DEADLINE_RELEASE_SCHEDULER_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define DRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define DRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/drs_pkg.sv =====
// Package: shared codes and types of the deadline release scheduler.
package drs_pkg;

   localparam int DEADLINE_BITS = 48;
   localparam int LEAD_BITS     = 24;
   localparam int STATUS_BITS   = 3;
   localparam int OUT_SESS_BITS = 8;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_REARM  = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_RELEASED  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NONE_DUE  = 3'd4;

   // Operation broadcast to every cell at once.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_MATCH,
      OP_REMOVE,
      OP_PLACE,
      OP_DUE,
      OP_RELEASE
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [DEADLINE_BITS-1:0] deadline;
      logic [DEADLINE_BITS:0]   horizon;
   } bcast_type;

endpackage

// ===== rtl/drs_cell.sv =====
// One slot of the sorted table: holds an entry and shifts with its neighbors.
module drs_cell #(
   parameter int SESSION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drs_pkg::bcast_type                  bcast,
   input  logic [SESSION_BITS-1:0]             key,
   input  logic [drs_pkg::DEADLINE_BITS-1:0]   prev_deadline,
   input  logic [SESSION_BITS-1:0]             prev_session,
   input  logic                                prev_used,
   input  logic                                prev_armed,
   input  logic                                prev_after,
   input  logic                                prev_gone,
   input  logic [drs_pkg::DEADLINE_BITS-1:0]   next_deadline,
   input  logic [SESSION_BITS-1:0]             next_session,
   input  logic                                next_used,
   input  logic                                next_armed,
   input  logic                                rel_sel,
   output logic [drs_pkg::DEADLINE_BITS-1:0]   deadline_ff,
   output logic [SESSION_BITS-1:0]             session_ff,
   output logic                                used_ff,
   output logic                                armed_ff,
   output logic                                after,
   output logic                                gone,
   output logic                                hit,
   output logic                                due
);
   logic [drs_pkg::DEADLINE_BITS-1:0] deadline_in;
   logic [SESSION_BITS-1:0]           session_in;
   logic                              used_in, armed_in, match_ff, match_in;

   // after: this slot lies past the insertion point (chain of ORs).
   assign after = prev_after | ~used_ff | (deadline_ff > bcast.deadline);
   assign gone  = prev_gone | match_ff;
   assign hit   = used_ff & (session_ff == key);
   assign due   = used_ff & armed_ff &
                  (bcast.horizon >= {1'b0, deadline_ff});

   always_comb begin
      deadline_in = deadline_ff;
      session_in  = session_ff;
      used_in     = used_ff;
      armed_in    = armed_ff;
      match_in    = match_ff;
      case (bcast.op)
         drs_pkg::OP_MATCH: match_in = hit;
         drs_pkg::OP_REMOVE: begin
            // close the gap: slots at and past the match take the next one
            if (gone) begin
               deadline_in = next_deadline;
               session_in  = next_session;
               used_in     = next_used;
               armed_in    = next_armed;
            end
            match_in = 1'b0;
         end
         drs_pkg::OP_PLACE: begin
            if (after && !prev_after) begin
               deadline_in = bcast.deadline;
               session_in  = key;
               used_in     = 1'b1;
               armed_in    = 1'b1;
            end else if (after) begin
               deadline_in = prev_deadline;
               session_in  = prev_session;
               used_in     = prev_used;
               armed_in    = prev_armed;
            end
         end
         drs_pkg::OP_DUE:     match_in = due;
         drs_pkg::OP_RELEASE: if (rel_sel) begin
            match_in = 1'b0;
            armed_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
         session_ff  <= '0;
         used_ff     <= 1'b0;
         armed_ff    <= 1'b0;
         match_ff    <= 1'b0;
      end else begin
         deadline_ff <= deadline_in;
         session_ff  <= session_in;
         used_ff     <= used_in;
         armed_ff    <= armed_in;
         match_ff    <= match_in;
      end
   end
endmodule

// ===== rtl/deadline_release_scheduler_unit.sv =====
// Top level: sorted earliest-deadline table built as a row of shifting cells.
// Edits step through the match, remove and decide states; placing an entry adds the place state.
// A tick marks due slots in the due state, then gives one release per cycle in table order.
// A new request is taken only in the idle state, after the previous one has finished.
// busy drops in the cycle showing the final result; the receiver cannot stall.
// Synchronous active-high reset empties the table and clears lead_time.
module deadline_release_scheduler_unit #(
   parameter int TABLE_SLOTS  = 64,
   parameter int SESSION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [7:0]                         req_session_id,
   input  logic [drs_pkg::DEADLINE_BITS-1:0]  req_deadline,
   input  logic [drs_pkg::DEADLINE_BITS-1:0]  req_now,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [drs_pkg::LEAD_BITS-1:0]      csr_lead_time,
   output logic                               rsp_strobe,
   output logic [drs_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [7:0]                         rsp_released_session,
   output logic                               rsp_last
);
   localparam int N = TABLE_SLOTS;

   typedef enum logic [2:0] {
      S_IDLE, S_MATCH, S_REMOVE, S_DECIDE, S_PLACE, S_DUE, S_EMIT
   } state_type;

   state_type                          state_ff;
   logic [1:0]                         kind_ff;
   logic [SESSION_BITS-1:0]            key_ff;
   logic [drs_pkg::DEADLINE_BITS-1:0]  dl_ff;
   logic [drs_pkg::DEADLINE_BITS:0]    horizon_ff;
   logic [drs_pkg::LEAD_BITS-1:0]      lead_ff;
   logic                               found_ff, any_ff, full_ff;
   drs_pkg::bcast_type                 bcast;

   logic [drs_pkg::DEADLINE_BITS-1:0]  dl_q [N];
   logic [SESSION_BITS-1:0]            ss_q [N];
   logic [N-1:0] used_q, armed_q, after_w, gone_w, hit_w, due_w, mark_w, sel_w;
   logic [N-1:0] mark_ff;
   logic [7:0]                         sel_sess;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      bcast.deadline = dl_ff;
      bcast.horizon  = horizon_ff;
      case (state_ff)
         S_MATCH:  bcast.op = drs_pkg::OP_MATCH;
         S_REMOVE: bcast.op = found_ff ? drs_pkg::OP_REMOVE : drs_pkg::OP_HOLD;
         S_PLACE:  bcast.op = drs_pkg::OP_PLACE;
         S_DUE:    bcast.op = drs_pkg::OP_DUE;
         S_EMIT:   bcast.op = drs_pkg::OP_RELEASE;
         default:  bcast.op = drs_pkg::OP_HOLD;
      endcase
   end

   // Pick the lowest marked slot for release: one-hot via x & -x.
   assign sel_w = mark_ff & (~mark_ff + {{(N-1){1'b0}}, 1'b1});

   // Read the session of the selected slot through a one-hot OR mux.
   always_comb begin
      sel_sess = '0;
      for (int i = 0; i < N; i++)
         sel_sess = sel_sess | ({8{sel_w[i]}} & 8'(ss_q[i]));
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [drs_pkg::DEADLINE_BITS-1:0] pd, nd;
      logic [SESSION_BITS-1:0]           ps, ns;
      logic                              pu, pa, pf, pg, nu, na;
      if (i == 0) begin : g_first
         assign pd = '0; assign ps = '0; assign pu = 1'b0; assign pa = 1'b0;
         assign pf = 1'b0; assign pg = 1'b0;
      end else begin : g_mid
         assign pd = dl_q[i-1]; assign ps = ss_q[i-1];
         assign pu = used_q[i-1]; assign pa = armed_q[i-1];
         assign pf = after_w[i-1]; assign pg = gone_w[i-1];
      end
      if (i == N-1) begin : g_last
         assign nd = '0; assign ns = '0; assign nu = 1'b0; assign na = 1'b0;
      end else begin : g_body
         assign nd = dl_q[i+1]; assign ns = ss_q[i+1];
         assign nu = used_q[i+1]; assign na = armed_q[i+1];
      end
      drs_cell #(.SESSION_BITS(SESSION_BITS)) u_cell (
         .clock, .reset, .bcast, .key(key_ff),
         .prev_deadline(pd), .prev_session(ps), .prev_used(pu),
         .prev_armed(pa), .prev_after(pf), .prev_gone(pg),
         .next_deadline(nd), .next_session(ns), .next_used(nu),
         .next_armed(na), .rel_sel(sel_w[i]),
         .deadline_ff(dl_q[i]), .session_ff(ss_q[i]), .used_ff(used_q[i]),
         .armed_ff(armed_q[i]), .after(after_w[i]), .gone(gone_w[i]),
         .hit(hit_w[i]), .due(due_w[i])
      );
      // each cell also keeps its own match flag; mirror due marks here
      assign mark_w[i] = due_w[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         lead_ff    <= '0;
         rsp_strobe <= 1'b0;
         mark_ff    <= '0;
         found_ff   <= 1'b0;
         any_ff     <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         if (csr_valid && csr_ready) lead_ff <= csr_lead_time;
         case (state_ff)
            S_IDLE: if (start) begin
               kind_ff    <= req_kind;
               key_ff     <= SESSION_BITS'(req_session_id);
               dl_ff      <= req_deadline;
               horizon_ff <= {1'b0, req_now} +
                             {{(drs_pkg::DEADLINE_BITS-drs_pkg::LEAD_BITS+1){1'b0}},
                              lead_ff};
               full_ff    <= used_q[N-1];
               state_ff   <= (req_kind == drs_pkg::KIND_TICK) ? S_DUE : S_MATCH;
            end
            S_MATCH: begin
               found_ff <= |hit_w;
               state_ff <= S_REMOVE;
            end
            S_REMOVE: state_ff <= S_DECIDE;
            S_DECIDE: begin
               // hold the response until the table is updated
               rsp_released_session <= 8'(key_ff);
               rsp_last             <= 1'b1;
               if (kind_ff == drs_pkg::KIND_DELETE || !found_ff &&
                   (kind_ff == drs_pkg::KIND_REARM || full_ff)) begin
                  rsp_strobe <= 1'b1;
                  rsp_status <= !found_ff ? ((kind_ff == drs_pkg::KIND_INSERT) ?
                                drs_pkg::ST_FULL : drs_pkg::ST_NOT_FOUND)
                                : drs_pkg::ST_DONE;
                  state_ff   <= S_IDLE;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               rsp_strobe <= 1'b1;
               rsp_status <= drs_pkg::ST_DONE;
               state_ff   <= S_IDLE;
            end
            S_DUE: begin
               mark_ff  <= mark_w;
               any_ff   <= |mark_w;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               rsp_strobe <= 1'b1;
               if (!any_ff) begin
                  rsp_status           <= drs_pkg::ST_NONE_DUE;
                  rsp_released_session <= '0;
                  rsp_last             <= 1'b1;
                  state_ff             <= S_IDLE;
               end else begin
                  rsp_status           <= drs_pkg::ST_RELEASED;
                  rsp_released_session <= sel_sess;
                  // advance: drop the emitted mark
                  mark_ff  <= mark_ff & ~sel_w;
                  rsp_last <= ((mark_ff & ~sel_w) == '0);
                  if ((mark_ff & ~sel_w) == '0) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/drs_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`include "deadline_release_scheduler_unit_macros.svh"
module drs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);
   `DRS_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `DRS_ASSERT_SAME(a_strobe_when_busy, clock, reset, rsp_strobe && !rsp_last, busy)
   `DRS_ASSERT_SAME(a_single_last, clock, reset, rsp_strobe && rsp_status != drs_pkg::ST_RELEASED, rsp_last)
   `DRS_ASSERT_SAME(a_status_range, clock, reset, rsp_strobe, rsp_status <= drs_pkg::ST_NONE_DUE)
endmodule

bind deadline_release_scheduler_unit drs_checker u_drs_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_status, .rsp_last
);
